### hw/rtl/stst_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package stst_pkg;

  localparam int DEPTH     = 64;
  localparam int KEY_WIDTH = 32;
  localparam int POS_WIDTH = $clog2(DEPTH);
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK   = 2'd0,
    STATUS_MISS = 2'd1,
    STATUS_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INSERT,
    ST_COMPARE,
    ST_SEARCH
  } state_t;

  typedef struct packed {
    logic                        operation;
    logic signed [KEY_WIDTH-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [POS_WIDTH-1:0] position;
    logic [CNT_WIDTH-1:0] fill_count;
  } out_word_t;

  typedef struct packed {
    logic                        ins_en;
    logic                        cmp_en;
    logic signed [KEY_WIDTH-1:0] key;
  } cell_ctl_t;

endpackage

`default_nettype wire

### hw/rtl/stst_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module stst_cell (
  input  wire logic                                  clk,
  input  wire stst_pkg::cell_ctl_t                   ctl,
  input  wire logic                                  valid,
  input  wire logic                                  at_end,
  input  wire logic signed [stst_pkg::KEY_WIDTH-1:0] prev_entry,
  input  wire logic                                  prev_gt,
  output logic signed [stst_pkg::KEY_WIDTH-1:0]      entry,
  output logic                                       gt,
  output logic                                       take,
  output logic                                       lt,
  output logic                                       eq
);

  logic signed [stst_pkg::KEY_WIDTH-1:0] entry_r;
  logic signed [stst_pkg::KEY_WIDTH-1:0] entry_nxt;
  logic                                  lt_r;
  logic                                  eq_r;
  logic                                  move;

  assign gt   = valid && (entry_r > ctl.key);
  assign move = ctl.ins_en && (gt || at_end);
  assign take = move && !prev_gt;

  always_comb begin
    entry_nxt = entry_r;
    if (move) begin
      entry_nxt = prev_gt ? prev_entry : ctl.key;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    if (ctl.cmp_en) begin
      lt_r <= entry_r < ctl.key;
      eq_r <= entry_r == ctl.key;
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

`default_nettype wire

### hw/rtl/sorted_table_insert_search_core.sv
// Sorted table of signed keys with ordered insert and bisection search.
// Input: a word (operation, key) is taken on a rising edge where start is
// high and busy is low. Busy stays high while the word is being worked on.
// Output: one result word per input word, shown for exactly one cycle with
// out_valid high; the receiver takes it at the edge ending that cycle and
// cannot hold it off.
// Each table entry lives in its own cell of a row. On an insert every larger
// key moves one cell up in parallel and the result is registered. A search
// first latches a compare flag in every cell, then walks the bisection one
// midpoint per cycle over those flags until it hits the key or the range is
// empty, and the result is registered.
// A new word can be accepted in the cycle its predecessor's result is shown.
// An insert into a full table is dropped and reported with the full status.
// Synchronous reset clears the state, result flag and fill count, emptying the
// table with no clearing pass; only entries below the fill count are used.
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_insert_search_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire stst_pkg::in_word_t in_data,
  output logic                    out_valid,
  output stst_pkg::out_word_t     out_data
);

  localparam int D  = stst_pkg::DEPTH;
  localparam int KW = stst_pkg::KEY_WIDTH;
  localparam int PW = stst_pkg::POS_WIDTH;
  localparam int CW = stst_pkg::CNT_WIDTH;

  stst_pkg::state_t    state_r;
  stst_pkg::state_t    state_nxt;
  logic signed [KW-1:0] key_r;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic [CW-1:0]        lo_r;
  logic [CW-1:0]        lo_nxt;
  logic [CW-1:0]        hi1_r;
  logic [CW-1:0]        hi1_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  stst_pkg::out_word_t  out_r;
  stst_pkg::out_word_t  out_nxt;

  stst_pkg::cell_ctl_t  ctl;
  logic signed [KW-1:0] entry [D];
  logic [D-1:0]         gt;
  logic [D-1:0]         take;
  logic [D-1:0]         lt;
  logic [D-1:0]         eq;
  logic [PW-1:0]        ins_pos;
  logic                 full;
  logic                 accept;
  logic [CW:0]          mid_sum;
  logic [PW-1:0]        mid;

  assign accept = start && !busy;
  assign full   = count_r == CW'(D);

  for (genvar i = 0; i < D; i++) begin : g_cell
    logic signed [KW-1:0] prev_entry;
    logic                 prev_gt;

    if (i == 0) begin : g_first
      assign prev_entry = '0;
      assign prev_gt    = 1'b0;
    end else begin : g_rest
      assign prev_entry = entry[i-1];
      assign prev_gt    = gt[i-1];
    end

    stst_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid      (CW'(i) < count_r),
      .at_end     (CW'(i) == count_r),
      .prev_entry (prev_entry),
      .prev_gt    (prev_gt),
      .entry      (entry[i]),
      .gt         (gt[i]),
      .take       (take[i]),
      .lt         (lt[i]),
      .eq         (eq[i])
    );
  end

  always_comb begin
    ins_pos = '0;
    for (int i = 0; i < D; i++) begin
      if (take[i]) begin
        ins_pos = ins_pos | PW'(i);
      end
    end
  end

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi1_r} - (CW + 1)'(1);
  assign mid     = mid_sum[PW:1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      stst_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.operation == stst_pkg::OP_SEARCH) ?
                      stst_pkg::ST_COMPARE : stst_pkg::ST_INSERT;
        end
      end
      stst_pkg::ST_INSERT:  state_nxt = stst_pkg::ST_IDLE;
      stst_pkg::ST_COMPARE: state_nxt = stst_pkg::ST_SEARCH;
      stst_pkg::ST_SEARCH: begin
        if (lo_r >= hi1_r || eq[mid]) begin
          state_nxt = stst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stst_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.ins_en         = 1'b0;
    ctl.cmp_en         = 1'b0;
    ctl.key            = key_r;
    count_nxt          = count_r;
    lo_nxt             = lo_r;
    hi1_nxt            = hi1_r;
    out_valid_nxt      = 1'b0;
    out_nxt.status     = stst_pkg::STATUS_OK;
    out_nxt.position   = '0;
    out_nxt.fill_count = count_r;
    unique case (state_r)
      stst_pkg::ST_IDLE: begin
      end
      stst_pkg::ST_INSERT: begin
        out_valid_nxt = 1'b1;
        if (full) begin
          out_nxt.status = stst_pkg::STATUS_FULL;
        end else begin
          ctl.ins_en         = 1'b1;
          count_nxt          = count_r + CW'(1);
          out_nxt.position   = ins_pos;
          out_nxt.fill_count = count_r + CW'(1);
        end
      end
      stst_pkg::ST_COMPARE: begin
        ctl.cmp_en = 1'b1;
        lo_nxt     = '0;
        hi1_nxt    = count_r;
      end
      stst_pkg::ST_SEARCH: begin
        if (lo_r >= hi1_r) begin
          out_valid_nxt  = 1'b1;
          out_nxt.status = stst_pkg::STATUS_MISS;
        end else if (eq[mid]) begin
          out_valid_nxt    = 1'b1;
          out_nxt.position = mid;
        end else if (lt[mid]) begin
          lo_nxt = CW'(mid) + CW'(1);
        end else begin
          hi1_nxt = CW'(mid);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stst_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_data.key;
    end
    lo_r  <= lo_nxt;
    hi1_r <= hi1_nxt;
    out_r <= out_nxt;
  end

  assign busy      = state_r != stst_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_result_when_idle : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fill_count <= CW'(D)))
    else $error("fill count beyond table depth");

  a_full_position : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == stst_pkg::STATUS_FULL) |->
      (out_data.position == '0 && out_data.fill_count == CW'(D)))
    else $error("full status with bad position or count");
`endif

endmodule

`default_nettype wire

### sim/tb_sorted_table_insert_search_core.sv
`timescale 1ns / 1ps

module tb_sorted_table_insert_search_core;
  import stst_pkg::*;

  localparam int N_RANDOM = 630;
  localparam int CALM_TAIL = 100;
  localparam int SETTLE_CYCLES = 12;
  localparam int DRAIN_LIMIT = 2000;

  class table_scoreboard;
    logic signed [KEY_WIDTH-1:0] keys [DEPTH];
    int fill = 0;
    out_word_t expected_q[$];
    int errors = 0;
    int inserts = 0;
    int rejects = 0;
    int searches = 0;
    int hits = 0;

    task report(string msg);
      $display("[%0t] %s", $realtime, msg);
      errors++;
    endtask

    // Works out the result of one accepted word and updates the table copy.
    function void note_word(in_word_t w);
      logic signed [KEY_WIDTH-1:0] k;
      out_word_t res;
      int pos;
      int lo;
      int hi;
      int mid;
      k = w.key;
      res = '0;
      if (w.operation == OP_INSERT) begin
        inserts++;
        if (fill >= DEPTH) begin
          rejects++;
          res.status = STATUS_FULL;
        end else begin
          pos = fill;
          while (pos > 0 && keys[pos-1] > k) begin
            keys[pos] = keys[pos-1];
            pos--;
          end
          keys[pos] = k;
          fill++;
          res.status = STATUS_OK;
          res.position = pos[POS_WIDTH-1:0];
        end
      end else begin
        searches++;
        res.status = STATUS_MISS;
        lo = 0;
        hi = fill - 1;
        while (lo <= hi) begin
          mid = (lo + hi) / 2;
          if (keys[mid] == k) begin
            res.status = STATUS_OK;
            res.position = mid[POS_WIDTH-1:0];
            hits++;
            break;
          end else if (k > keys[mid]) begin
            lo = mid + 1;
          end else begin
            hi = mid - 1;
          end
        end
      end
      res.fill_count = fill[CNT_WIDTH-1:0];
      expected_q.push_back(res);
    endfunction

    task check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result word %h", got));
      end else begin
        exp_w = expected_q.pop_front();
        if (got.status !== exp_w.status)
          report($sformatf("status %0d, expected %0d", got.status, exp_w.status));
        if (got.position !== exp_w.position)
          report($sformatf("position %0d, expected %0d", got.position, exp_w.position));
        if (got.fill_count !== exp_w.fill_count)
          report($sformatf("fill_count %0d, expected %0d", got.fill_count,
                           exp_w.fill_count));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_word_t in_data = '0;
  logic out_valid;
  out_word_t out_data;

  table_scoreboard sb;

  sorted_table_insert_search_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) sb.check_word(out_data);
  end

  task automatic send_word(logic op, logic signed [KEY_WIDTH-1:0] k);
    in_word_t w;
    w.operation = op;
    w.key = k;
    start <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(w);
  endtask

  task automatic idle_burst();
    start <= 1'b0;
    repeat ($urandom_range(1, 9)) @(posedge clk);
  endtask

  task automatic drain_results(int max_cycles);
    int n;
    n = 0;
    start <= 1'b0;
    do begin
      @(posedge clk);
      n++;
    end while (sb.expected_q.size() != 0 && n < max_cycles);
  endtask

  // Mixes keys already held (and their neighbors) with small, extreme and
  // fully random values so that hits, misses and duplicates all occur.
  function automatic logic signed [KEY_WIDTH-1:0] pick_key();
    logic signed [KEY_WIDTH-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2: k = $urandom;
      3, 4: k = $signed($urandom_range(0, 16)) - 8;
      5: begin
        case ($urandom_range(0, 3))
          0: k = {1'b1, {(KEY_WIDTH-1){1'b0}}};
          1: k = {1'b0, {(KEY_WIDTH-1){1'b1}}};
          2: k = {1'b1, {(KEY_WIDTH-2){1'b0}}, 1'b1};
          default: k = {1'b0, {(KEY_WIDTH-2){1'b1}}, 1'b0};
        endcase
      end
      default: begin
        if (sb.fill == 0) begin
          k = $urandom;
        end else begin
          k = sb.keys[$urandom_range(0, sb.fill - 1)];
          case ($urandom_range(0, 3))
            0: k = k + 1;
            1: k = k - 1;
            default: ;
          endcase
        end
      end
    endcase
    return k;
  endfunction

  initial begin
    logic signed [KEY_WIDTH-1:0] kmin;
    logic signed [KEY_WIDTH-1:0] kmax;
    logic op;
    int i;
    sb = new;
    kmin = {1'b1, {(KEY_WIDTH-1){1'b0}}};
    kmax = {1'b0, {(KEY_WIDTH-1){1'b1}}};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_SEARCH, 0);
    send_word(OP_INSERT, kmin);
    send_word(OP_INSERT, kmax);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, -1);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, kmin);
    send_word(OP_INSERT, kmax);
    send_word(OP_SEARCH, kmin);
    send_word(OP_SEARCH, kmax);
    send_word(OP_SEARCH, 0);
    send_word(OP_SEARCH, -1);
    send_word(OP_SEARCH, 1);
    send_word(OP_SEARCH, -2);
    send_word(OP_SEARCH, kmin + 1);
    send_word(OP_SEARCH, kmax - 1);
    drain_results(DRAIN_LIMIT);

    for (i = 0; i < N_RANDOM; i++) begin
      if (sb.fill < DEPTH)
        op = ($urandom_range(0, 3) == 0) ? OP_INSERT : OP_SEARCH;
      else
        op = ($urandom_range(0, 7) == 0) ? OP_INSERT : OP_SEARCH;
      send_word(op, pick_key());
      if (i == N_RANDOM / 2)
        drain_results(DRAIN_LIMIT);
      else if (i < N_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
        idle_burst();
    end

    drain_results(DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));

    $display("Covered %0d inserts (%0d dropped on a full table) and %0d searches",
             sb.inserts, sb.rejects, sb.searches);
    $display("with %0d hits; the table ended holding %0d keys.", sb.hits, sb.fill);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Timeout waiting for the block.");
    $display("Mismatches found");
    $finish;
  end

endmodule

### sim.f
hw/rtl/stst_pkg.sv
hw/rtl/stst_cell.sv
hw/rtl/sorted_table_insert_search_core.sv
sim/tb_sorted_table_insert_search_core.sv
